FILE: src/bsos_pkg.sv
// shared types and constants for the bitmap set and ordered scan block
package bsos_pkg;

  localparam int KEY_W  = 16;
  localparam int PTR_W  = 17;
  localparam int BYTE_W = 8;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS,
    ST_SCAN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_wr;    // write zero at the clear counter
    logic accept_ins;  // insert word taken, read its byte
    logic accept_rd;   // read-next word taken, read byte at pointer
    logic ins_wr;      // write merged byte back
    logic scan_adv;    // step pointer to next byte and read it
    logic emit;        // load result register and update pointer
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;  // clear counter at last byte
    logic scan_done;   // hit found or range exhausted
    logic out_free;    // result register can take a word
  } sts_t;

endpackage

FILE: src/bsos_ram.sv
// generic simple dual port ram with registered read
module bsos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/bsos_ctrl.sv
// controller state machine: clearing pass, insert and scan sequencing
module bsos_ctrl
  import bsos_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_func,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_func == FUNC_READ) begin
            cmd.accept_rd = 1'b1;
            state_nxt     = ST_SCAN;
          end else begin
            cmd.accept_ins = 1'b1;
            state_nxt      = ST_INS;
          end
        end
      end
      ST_INS: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          if (sts.out_free) begin
            cmd.emit  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

FILE: src/bsos_dp.sv
// datapath: bit store, scan pointer, byte search and result register
module bsos_dp
  import bsos_pkg::*;
#(
  parameter int STORE_BYTES = 8192
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [KEY_W-1:0] in_key,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [KEY_W-1:0] out_sorted_key,
  output logic             out_found
);

  localparam int LIMIT  = (STORE_BYTES * 8 < 65536) ? STORE_BYTES * 8 : 65536;
  localparam int DEPTH  = LIMIT / 8;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] LIMIT_P = PTR_W'(LIMIT);

  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [ADDR_W-1:0] ins_addr_r;
  logic [BYTE_W-1:0] ins_mask_r;
  logic              ins_ok_r;
  logic              out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]  out_key_r;
  logic              out_found_r;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [BYTE_W-1:0] wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [BYTE_W-1:0] rdata;

  logic              key_ok;
  logic              ptr_ok;
  logic              beyond;
  logic [BYTE_W-1:0] masked;
  logic              hit;
  logic [2:0]        lead;
  logic [KEY_W-1:0]  hit_key;
  logic [PTR_W-1:0]  next_word_ptr;
  logic              next_ok;

  // lowest key of a byte sits in its msb
  assign key_ok        = {1'b0, in_key} < LIMIT_P;
  assign ptr_ok        = ptr_r < LIMIT_P;
  assign beyond        = !ptr_ok;
  assign masked        = rdata & (8'hFF >> ptr_r[2:0]);
  assign hit           = |masked;
  assign next_word_ptr = {ptr_r[PTR_W-1:3] + 14'd1, 3'b000};
  assign next_ok       = next_word_ptr < LIMIT_P;

  always_comb begin
    lead = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (masked[i]) begin
        lead = 3'(BYTE_W - 1 - i);
      end
    end
  end

  assign hit_key = {ptr_r[KEY_W-1:3], lead};

  // memory port steering
  always_comb begin
    we    = cmd.clear_wr | (cmd.ins_wr & ins_ok_r);
    waddr = cmd.clear_wr ? clr_addr_r : ins_addr_r;
    wdata = cmd.clear_wr ? '0 : (rdata | ins_mask_r);
    re    = (cmd.accept_ins & key_ok) | (cmd.accept_rd & ptr_ok) |
            (cmd.scan_adv & next_ok);
    if (cmd.accept_ins) begin
      raddr = in_key[ADDR_W+2:3];
    end else if (cmd.scan_adv) begin
      raddr = next_word_ptr[ADDR_W+2:3];
    end else begin
      raddr = ptr_r[ADDR_W+2:3];
    end
  end

  bsos_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.scan_adv) begin
      ptr_nxt = next_word_ptr;
    end else if (cmd.emit) begin
      ptr_nxt = (hit && !beyond) ? ({1'b0, hit_key} + 17'd1) : '0;
    end
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.clear_wr) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_ins) begin
      ins_addr_r <= in_key[ADDR_W+2:3];
      ins_mask_r <= 8'h80 >> in_key[2:0];
      ins_ok_r   <= key_ok;
    end
    if (cmd.emit) begin
      out_key_r   <= (hit && !beyond) ? hit_key : '0;
      out_found_r <= hit && !beyond;
    end
  end

  assign sts.clear_last = clr_addr_r == ADDR_W'(DEPTH - 1);
  assign sts.scan_done  = beyond | hit;
  assign sts.out_free   = !out_valid_r | !out_stall;

  assign out_valid      = out_valid_r;
  assign out_sorted_key = out_key_r;
  assign out_found      = out_found_r;

endmodule

FILE: src/bitmap_set_and_ordered_scan_top.sv
// top level of the bitmap set and ordered scan block
// Keys are held one bit each in a byte-wide ram of min(STORE_BYTES, 8192) bytes,
// key k at bit 7-(k%8) of byte k/8. An insert word (func 0) sets its key's bit
// and gives no result; it does a read and a merged write back on the store's
// single read and single write port. A read-next word (func 1) scans upward
// from the scan pointer one byte per cycle, masking bits below the pointer
// and picking the lowest set key; each further byte stepped over lengthens
// the read, so sparse stores cost more. An exhausted pass also steps past the
// last byte, then answers found 0, key 0 and rewinds the pointer to 0. The ram
// read port, one byte per cycle, sets the scan rate. One word is worked on at
// a time; a finished result waits in the output register while the next word
// is accepted. After reset a clearing pass writes zero to every byte, with
// in_stall held high.
module bitmap_set_and_ordered_scan_top
  import bsos_pkg::*;
#(
  parameter int STORE_BYTES = 8192
) (
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_func,
  input  logic [KEY_W-1:0] in_key,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [KEY_W-1:0] out_sorted_key,
  output logic             out_found
);

  cmd_t cmd;
  sts_t sts;

  // sequencing: clear pass, insert read-modify-write, byte scan
  bsos_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store, pointer and result register
  bsos_dp #(
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_key         (in_key),
    .cmd            (cmd),
    .sts            (sts),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_sorted_key (out_sorted_key),
    .out_found      (out_found)
  );

  // an insert never brings up a result right after it
  a_ins_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_func == FUNC_INSERT) |=> !$rose(out_valid))
    else $error("result appeared after insert");

  // no word taken during the clearing pass
  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_wr |-> in_stall)
    else $error("input open during clear");

  // a result is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid && out_stall))
    else $error("result overwrote a waiting word");

  // the write back of an insert is a single cycle
  a_ins_single: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_wr |=> !cmd.ins_wr)
    else $error("insert write repeated");

endmodule

FILE: dv/tb_top.sv
// self-checking testbench for the bitmap set and ordered scan block
module tb_top;
  import bsos_pkg::*;

  localparam int STORE_BYTES    = 8192;
  localparam int KEY_SPACE      = 1 << KEY_W;
  localparam int SCAN_LIMIT     = (STORE_BYTES * 8 < KEY_SPACE) ? STORE_BYTES * 8 : KEY_SPACE;
  localparam int RANDOM_WORDS   = 1825;
  // longest correct silence: the clearing pass or one read over an empty store
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic [KEY_W-1:0] sorted_key;
    logic             found;
  } scan_result_t;

  typedef struct packed {
    logic             func;
    logic [KEY_W-1:0] key;
    logic             typed;   // expected result written into the row
    logic [KEY_W-1:0] exp_key;
    logic             exp_found;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_func = FUNC_INSERT;
  logic [KEY_W-1:0] in_key = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [KEY_W-1:0] out_sorted_key;
  logic             out_found;

  // mirror of the block's key set and scan position
  bit               key_held [SCAN_LIMIT];
  logic [PTR_W-1:0] next_pos = '0;
  logic [KEY_W-1:0] key_log [$];
  logic [KEY_W-1:0] last_key = '0;

  scan_result_t owed_scan_results [$];
  scan_result_t head_result;

  int  errors = 0;
  int  n_inserts = 0;
  int  n_reads = 0;
  int  n_found = 0;
  int  n_exhausted = 0;
  int  stall_left = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;

  // directed rows: extremes, duplicates, byte boundaries, ignored key on read,
  // inserts above and below the scan position, pointer past the end, rewind
  stim_row_t directed_rows [25] = '{
    '{FUNC_READ,   16'd0,     1'b1, 16'd0,     1'b0},  // empty store, exhausted
    '{FUNC_INSERT, 16'd65535, 1'b0, 16'd0,     1'b0},
    '{FUNC_INSERT, 16'd0,     1'b0, 16'd0,     1'b0},
    '{FUNC_INSERT, 16'd0,     1'b0, 16'd0,     1'b0},  // duplicate merges
    '{FUNC_INSERT, 16'd32768, 1'b0, 16'd0,     1'b0},
    '{FUNC_INSERT, 16'd1,     1'b0, 16'd0,     1'b0},
    '{FUNC_INSERT, 16'd7,     1'b0, 16'd0,     1'b0},
    '{FUNC_INSERT, 16'd8,     1'b0, 16'd0,     1'b0},
    '{FUNC_READ,   16'hFFFF,  1'b1, 16'd0,     1'b1},  // key field ignored
    '{FUNC_READ,   16'd0,     1'b1, 16'd1,     1'b1},
    '{FUNC_READ,   16'd0,     1'b0, 16'd0,     1'b0},
    '{FUNC_READ,   16'd0,     1'b0, 16'd0,     1'b0},
    '{FUNC_INSERT, 16'd4,     1'b0, 16'd0,     1'b0},  // below the scan position
    '{FUNC_INSERT, 16'd40000, 1'b0, 16'd0,     1'b0},  // above the scan position
    '{FUNC_READ,   16'd0,     1'b1, 16'd32768, 1'b1},
    '{FUNC_READ,   16'd0,     1'b0, 16'd0,     1'b0},
    '{FUNC_READ,   16'd0,     1'b1, 16'd65535, 1'b1},
    '{FUNC_READ,   16'd0,     1'b1, 16'd0,     1'b0},  // pointer past the end
    '{FUNC_READ,   16'd0,     1'b1, 16'd0,     1'b1},  // after the rewind
    '{FUNC_READ,   16'd0,     1'b0, 16'd0,     1'b0},
    '{FUNC_READ,   16'd0,     1'b0, 16'd0,     1'b0},
    '{FUNC_INSERT, 16'd21845, 1'b0, 16'd0,     1'b0},
    '{FUNC_INSERT, 16'd43690, 1'b0, 16'd0,     1'b0},
    '{FUNC_READ,   16'd0,     1'b0, 16'd0,     1'b0},
    '{FUNC_READ,   16'd0,     1'b0, 16'd0,     1'b0}
  };

  bitmap_set_and_ordered_scan_top #(
    .STORE_BYTES(STORE_BYTES)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_key        (in_key),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sorted_key(out_sorted_key),
    .out_found     (out_found)
  );

  always #10 clk = ~clk;

  // apply one accepted word to the mirror; returns 1 when it owes a result
  function automatic bit apply_word_to_bitmap(input logic func, input logic [KEY_W-1:0] key,
                                              output scan_result_t res);
    int p;
    res = '0;
    if (func == FUNC_INSERT) begin
      if (int'(key) < SCAN_LIMIT) key_held[key] = 1'b1;
      return 1'b0;
    end
    for (p = int'(next_pos); p < SCAN_LIMIT; p++) begin
      if (key_held[p]) begin
        res.sorted_key = p[KEY_W-1:0];
        res.found      = 1'b1;
        next_pos       = PTR_W'(p + 1);
        return 1'b1;
      end
    end
    // nothing left in this pass: rewind
    next_pos = '0;
    return 1'b1;
  endfunction

  // insert keys: mostly uniform, plus clusters, duplicates, keys around the
  // scan position and single-bit patterns
  function automatic logic [KEY_W-1:0] pick_key();
    int mode;
    int bitpos;
    mode   = $urandom_range(0, 9);
    bitpos = $urandom_range(0, KEY_W - 1);
    case (mode)
      5, 6: pick_key = KEY_W'(int'(last_key) + int'($urandom_range(0, 24)) - 12);
      7: begin
        if (key_log.size() > 0) pick_key = key_log[$urandom_range(0, key_log.size() - 1)];
        else pick_key = KEY_W'($urandom);
      end
      8: pick_key = KEY_W'(int'(next_pos) + int'($urandom_range(0, 16)) - 8);
      9: begin
        case ($urandom_range(0, 3))
          0: pick_key = '0;
          1: pick_key = '1;
          2: pick_key = KEY_W'(1) << bitpos;
          default: pick_key = ~(KEY_W'(1) << bitpos);
        endcase
      end
      default: pick_key = KEY_W'($urandom);
    endcase
  endfunction

  // drive one word, wait for the handshake, then record what it owes
  task automatic send_word(input logic func, input logic [KEY_W-1:0] key, input bit typed,
                           input scan_result_t typed_res);
    scan_result_t res;
    bit owes;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_key   <= key;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    owes = apply_word_to_bitmap(func, key, res);
    if (owes) owed_scan_results.push_back(typed ? typed_res : res);
    if (func == FUNC_INSERT) begin
      n_inserts++;
      last_key = key;
      key_log.push_back(key);
    end else begin
      n_reads++;
    end
    @(negedge clk);
  endtask

  // result side back-pressure in random bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // compare each result word against the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (out_found === 1'b1) n_found++;
      else n_exhausted++;
      if (owed_scan_results.size() == 0) begin
        errors++;
        $error("result word with none owed: sorted_key %0d found %0b",
               out_sorted_key, out_found);
      end else begin
        head_result = owed_scan_results.pop_front();
        if (out_sorted_key !== head_result.sorted_key) begin
          errors++;
          $error("sorted_key: expected %0d, got %0d", head_result.sorted_key, out_sorted_key);
        end
        if (out_found !== head_result.found) begin
          errors++;
          $error("found: expected %0b, got %0b", head_result.found, out_found);
        end
      end
    end
  end

  // give up when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int i;
    int sent;
    int n_ins;
    int n_rd;
    scan_result_t typed_res;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed rows; the block holds in_stall through its clearing pass
    for (i = 0; i < $size(directed_rows); i++) begin
      typed_res.sorted_key = directed_rows[i].exp_key;
      typed_res.found      = directed_rows[i].exp_found;
      send_word(directed_rows[i].func, directed_rows[i].key, directed_rows[i].typed, typed_res);
    end

    // random part: mostly insert bursts followed by read runs, some mixed noise;
    // the final tenth runs with no idling on either side
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      no_idle = (sent > RANDOM_WORDS * 9 / 10) || ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(4, 20)) begin
          if ($urandom_range(0, 1) == 0) send_word(FUNC_INSERT, pick_key(), 1'b0, '0);
          else send_word(FUNC_READ, KEY_W'($urandom), 1'b0, '0);
          sent++;
        end
      end else begin
        n_ins = $urandom_range(1, 30);
        n_rd  = $urandom_range(1, 35);
        repeat (n_ins) begin
          send_word(FUNC_INSERT, pick_key(), 1'b0, '0);
          sent++;
        end
        repeat (n_rd) begin
          send_word(FUNC_READ, KEY_W'($urandom), 1'b0, '0);
          sent++;
        end
      end
    end
    in_valid <= 1'b0;

    while (owed_scan_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d words driven: %0d inserts, %0d read-next", n_inserts + n_reads, n_inserts,
             n_reads);
    $display("%0d keys returned in ascending order, %0d exhausted passes rewound", n_found,
             n_exhausted);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: bitmap_set_and_ordered_scan_top.f
src/bsos_pkg.sv
src/bsos_ram.sv
src/bsos_ctrl.sv
src/bsos_dp.sv
src/bitmap_set_and_ordered_scan_top.sv
dv/tb_top.sv
